// File: sv/generational_slot_allocator_macros.svh
// assertion macros for the generational slot allocator
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication, reset masks the check
`define GSA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define GSA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gsa_pkg.sv
// shared types and constants of the generational slot allocator
`default_nettype none

package gsa_pkg;

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_BEGIN  = 3'd3,
        CMD_NEXT   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2,
        ST_END   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_PICK  = 2'd2,
        S_EXEC  = 2'd3
    } t_state;

    localparam logic [1:0] CFG_ACTIVE_SLOTS = 2'd0;
    localparam logic [1:0] CFG_ITEM_BYTES   = 2'd1;
    localparam logic [1:0] CFG_TYPE_TAG     = 2'd2;

    localparam logic [8:0]  RST_ACTIVE_SLOTS = 9'd256;
    localparam logic [12:0] RST_ITEM_BYTES   = 13'd16;
    localparam logic [15:0] RST_TYPE_TAG     = 16'd0;

    typedef struct packed {
        logic start;
        logic want_used;
        logic upd_en;
        logic upd_val;
    } t_bm_ctl;

endpackage

`default_nettype wire

// File: sv/gsa_ram.sv
// single-port-write, registered-read memory for slot state
`default_nettype none

module gsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/gsa_bitmap.sv
// in-use bitmap with a two-step lowest-slot search
`default_nettype none

module gsa_bitmap #(
    parameter int SLOTS = 256,
    localparam int AW = $clog2(SLOTS),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gsa_pkg::t_bm_ctl i_ctl,
    input  wire logic [CW-1:0]    i_lo,
    input  wire logic [CW-1:0]    i_hi,
    input  wire logic [AW-1:0]    i_upd_idx,
    input  wire logic [AW-1:0]    i_probe_idx,
    output logic                  o_probe_mark,
    output logic                  o_found,
    output logic      [AW-1:0]    o_idx
);

    localparam int GRP  = 16;
    localparam int GB   = 4;
    localparam int NGRP = (SLOTS + GRP - 1) / GRP;
    localparam int PW   = NGRP * GRP;
    localparam int GIW  = (NGRP > 1) ? $clog2(NGRP) : 1;

    logic [SLOTS-1:0] r_used;
    logic [NGRP-1:0]  r_grp_hit;
    logic [NGRP-1:0]  n_grp_hit;
    logic             r_want;
    logic [CW-1:0]    r_lo;
    logic [CW-1:0]    r_hi;
    logic [PW-1:0]    c_start;
    logic [PW-1:0]    c_pick;
    logic [GIW-1:0]   c_gsel;
    logic [GRP-1:0]   c_grp_bits;
    logic [GB-1:0]    c_bsel;

    // candidate bits: free slots for allocate, used slots for iteration
    always_comb begin
        c_start = '0;
        c_pick  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            c_start[i] = (i_ctl.want_used ? r_used[i] : ~r_used[i])
                       & (CW'(i) >= i_lo) & (CW'(i) < i_hi);
            c_pick[i]  = (r_want ? r_used[i] : ~r_used[i])
                       & (CW'(i) >= r_lo) & (CW'(i) < r_hi);
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_hit[g] = |c_start[g*GRP +: GRP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_grp_hit <= n_grp_hit;
            r_want    <= i_ctl.want_used;
            r_lo      <= i_lo;
            r_hi      <= i_hi;
        end
    end

    // lowest hit group, then lowest bit inside it
    always_comb begin
        c_gsel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_hit[g]) begin
                c_gsel = GIW'(g);
            end
        end
    end

    always_comb begin
        c_grp_bits = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (c_gsel == GIW'(g)) begin
                c_grp_bits = c_pick[g*GRP +: GRP];
            end
        end
    end

    always_comb begin
        c_bsel = '0;
        for (int b = GRP - 1; b >= 0; b--) begin
            if (c_grp_bits[b]) begin
                c_bsel = GB'(b);
            end
        end
    end

    assign o_found = |r_grp_hit;
    assign o_idx   = AW'({c_gsel, c_bsel});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctl.upd_en) begin
            r_used[i_upd_idx] <= i_ctl.upd_val;
        end
    end

    assign o_probe_mark = r_used[i_probe_idx];

endmodule

`default_nettype wire

// File: sv/generational_slot_allocator.sv
// Generational slot allocator top level: handles, pool memories and result register.
// After reset the block clears its generation memory, one slot per cycle, and holds
// o_in_ready low meanwhile; configuration writes are taken at any time.
// Each command passes through the states S_IDLE, S_PICK and S_EXEC: on acceptance the
// per-group hit flags of the in-use bitmap are registered, in S_PICK the lowest slot is
// picked and the generation and owner memory reads are issued together with the offset
// multiply, and in S_EXEC the block writes back and loads the output register, waiting
// there while the result register holds an untaken result. The block takes no new item
// until it has returned to S_IDLE after committing the last one.
`default_nettype none

`include "generational_slot_allocator_macros.svh"

module generational_slot_allocator #(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [7:0]  i_slot,
    input  wire logic [15:0] i_handle_gen,
    input  wire logic [31:0] i_owner_entity,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [1:0]  o_status,
    output logic      [7:0]  o_out_slot,
    output logic      [15:0] o_out_gen,
    output logic      [15:0] o_out_type,
    output logic      [31:0] o_out_entity,
    output logic      [19:0] o_byte_offset
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = AW + 13;

    gsa_pkg::t_state  r_state;
    gsa_pkg::t_state  n_state;
    logic [AW-1:0]    r_clr;
    logic [8:0]       r_active;
    logic [12:0]      r_item;
    logic [15:0]      r_type;
    logic [CW-1:0]    r_cursor;
    logic [CW-1:0]    c_lim;

    gsa_pkg::t_cmd    r_cmd;
    logic [7:0]       r_slot;
    logic [15:0]      r_hg;
    logic [31:0]      r_ent;
    logic             r_found;
    logic [AW-1:0]    r_idx;
    logic [19:0]      r_offset;

    logic             r_out_valid;
    gsa_pkg::t_status r_o_status;
    logic [7:0]       r_o_slot;
    logic [15:0]      r_o_gen;
    logic [15:0]      r_o_type;
    logic [31:0]      r_o_ent;
    logic [19:0]      r_o_off;

    logic             c_accept;
    logic             c_commit;
    gsa_pkg::t_cmd    c_in_cmd;
    gsa_pkg::t_bm_ctl c_bm_ctl;
    logic [CW-1:0]    c_lo;
    logic             bm_mark;
    logic             bm_found;
    logic [AW-1:0]    bm_idx;
    logic [AW-1:0]    c_sel_idx;
    logic [MW-1:0]    c_prod;
    logic [GEN_BITS-1:0] gen_rd;
    logic [31:0]      own_rd;
    logic [GEN_BITS-1:0] c_gen_inc;
    logic             c_gen_we;
    logic [AW-1:0]    c_gen_waddr;
    logic [GEN_BITS-1:0] c_gen_wdata;
    logic             c_own_we;
    logic             c_in_range;
    logic             c_gen_eq;

    gsa_pkg::t_status c_status;
    logic [7:0]       c_slot;
    logic [15:0]      c_gen;
    logic [15:0]      c_type;
    logic [31:0]      c_ent;
    logic [19:0]      c_off;
    logic             c_upd_en;
    logic             c_upd_val;
    logic             c_cur_we;
    logic [CW-1:0]    c_cur_next;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= gsa_pkg::RST_ACTIVE_SLOTS;
            r_item   <= gsa_pkg::RST_ITEM_BYTES;
            r_type   <= gsa_pkg::RST_TYPE_TAG;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gsa_pkg::CFG_ACTIVE_SLOTS: r_active <= i_cfg_data[8:0];
                gsa_pkg::CFG_ITEM_BYTES:   r_item   <= i_cfg_data[12:0];
                gsa_pkg::CFG_TYPE_TAG:     r_type   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign c_lim = (16'(r_active) > 16'(SLOTS)) ? CW'(SLOTS) : CW'(r_active);

    // control
    assign c_accept = i_in_valid && o_in_ready;
    assign c_commit = (r_state == gsa_pkg::S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            gsa_pkg::S_CLEAR: begin
                if (r_clr == AW'(SLOTS - 1)) begin
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            gsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = gsa_pkg::S_PICK;
                end
            end
            gsa_pkg::S_PICK: begin
                n_state = gsa_pkg::S_EXEC;
            end
            gsa_pkg::S_EXEC: begin
                if (c_commit) begin
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gsa_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsa_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == gsa_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // item capture and bitmap search
    assign c_in_cmd = gsa_pkg::t_cmd'(i_cmd);
    assign c_lo     = (c_in_cmd == gsa_pkg::CMD_NEXT) ? r_cursor : '0;

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_cmd  <= c_in_cmd;
            r_slot <= i_slot;
            r_hg   <= i_handle_gen;
            r_ent  <= i_owner_entity;
        end
    end

    always_comb begin
        c_bm_ctl.start     = c_accept;
        c_bm_ctl.want_used = (c_in_cmd == gsa_pkg::CMD_NEXT);
        c_bm_ctl.upd_en    = c_upd_en;
        c_bm_ctl.upd_val   = c_upd_val;
    end

    gsa_bitmap #(
        .SLOTS (SLOTS)
    ) u_bitmap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (c_bm_ctl),
        .i_lo         (c_lo),
        .i_hi         (c_lim),
        .i_upd_idx    (r_idx),
        .i_probe_idx  (r_idx),
        .o_probe_mark (bm_mark),
        .o_found      (bm_found),
        .o_idx        (bm_idx)
    );

    // slot pick, memory read and offset product
    assign c_sel_idx = (r_cmd == gsa_pkg::CMD_ALLOC || r_cmd == gsa_pkg::CMD_NEXT)
                     ? bm_idx : AW'(r_slot);
    assign c_prod    = MW'(c_sel_idx) * MW'(r_item);

    always_ff @(posedge i_clk) begin
        if (r_state == gsa_pkg::S_PICK) begin
            r_found  <= bm_found;
            r_idx    <= c_sel_idx;
            r_offset <= 20'(c_prod);
        end
    end

    assign c_gen_inc   = gen_rd + 1'b1;
    assign c_gen_we    = (r_state == gsa_pkg::S_CLEAR) || (c_commit
                       && r_cmd == gsa_pkg::CMD_ALLOC && r_found);
    assign c_gen_waddr = (r_state == gsa_pkg::S_CLEAR) ? r_clr : r_idx;
    assign c_gen_wdata = (r_state == gsa_pkg::S_CLEAR) ? '0 : c_gen_inc;
    assign c_own_we    = c_commit && r_cmd == gsa_pkg::CMD_ALLOC && r_found;

    gsa_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (c_gen_we),
        .i_waddr (c_gen_waddr),
        .i_wdata (c_gen_wdata),
        .i_re    (r_state == gsa_pkg::S_PICK),
        .i_raddr (c_sel_idx),
        .o_rdata (gen_rd)
    );

    gsa_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (c_own_we),
        .i_waddr (r_idx),
        .i_wdata (r_ent),
        .i_re    (r_state == gsa_pkg::S_PICK),
        .i_raddr (c_sel_idx),
        .o_rdata (own_rd)
    );

    // command results and writeback
    assign c_in_range = 16'(r_slot) < 16'(c_lim);
    assign c_gen_eq   = 32'(r_hg) == 32'(gen_rd);

    always_comb begin
        c_status   = gsa_pkg::ST_STALE;
        c_slot     = '0;
        c_gen      = '0;
        c_type     = '0;
        c_ent      = '0;
        c_off      = '0;
        c_upd_en   = 1'b0;
        c_upd_val  = 1'b0;
        c_cur_we   = 1'b0;
        c_cur_next = r_cursor;
        case (r_cmd)
            gsa_pkg::CMD_ALLOC: begin
                if (r_found) begin
                    c_status  = gsa_pkg::ST_OK;
                    c_slot    = 8'(r_idx);
                    c_gen     = 16'(c_gen_inc);
                    c_type    = r_type;
                    c_ent     = r_ent;
                    c_off     = r_offset;
                    c_upd_en  = c_commit;
                    c_upd_val = 1'b1;
                end else begin
                    c_status = gsa_pkg::ST_FULL;
                end
            end
            gsa_pkg::CMD_LOOKUP: begin
                if (c_in_range && bm_mark && c_gen_eq) begin
                    c_status = gsa_pkg::ST_OK;
                    c_slot   = 8'(r_idx);
                    c_gen    = 16'(gen_rd);
                    c_type   = r_type;
                    c_ent    = own_rd;
                    c_off    = r_offset;
                end
            end
            gsa_pkg::CMD_REMOVE: begin
                if (c_in_range && c_gen_eq) begin
                    c_status  = gsa_pkg::ST_OK;
                    c_upd_en  = c_commit;
                    c_upd_val = 1'b0;
                end
            end
            gsa_pkg::CMD_BEGIN: begin
                c_status   = gsa_pkg::ST_OK;
                c_cur_we   = c_commit;
                c_cur_next = '0;
            end
            gsa_pkg::CMD_NEXT: begin
                if (r_found) begin
                    c_status   = gsa_pkg::ST_OK;
                    c_slot     = 8'(r_idx);
                    c_gen      = 16'(gen_rd);
                    c_type     = r_type;
                    c_ent      = own_rd;
                    c_off      = r_offset;
                    c_cur_we   = c_commit;
                    c_cur_next = CW'(r_idx) + 1'b1;
                end else begin
                    c_status   = gsa_pkg::ST_END;
                    c_cur_we   = c_commit && (r_cursor < c_lim);
                    c_cur_next = c_lim;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (c_cur_we) begin
            r_cursor <= c_cur_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_commit) begin
            r_o_status <= c_status;
            r_o_slot   <= c_slot;
            r_o_gen    <= c_gen;
            r_o_type   <= c_type;
            r_o_ent    <= c_ent;
            r_o_off    <= c_off;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_out_slot    = r_o_slot;
    assign o_out_gen     = r_o_gen;
    assign o_out_type    = r_o_type;
    assign o_out_entity  = r_o_ent;
    assign o_byte_offset = r_o_off;

    `GSA_ASSERT_IMP(a_no_accept_in_clear, r_state == gsa_pkg::S_CLEAR, !o_in_ready, "item taken during clear")
    `GSA_ASSERT_NXT(a_stall_holds_exec, r_state == gsa_pkg::S_EXEC && r_out_valid && !i_out_ready, r_state == gsa_pkg::S_EXEC, "result committed over a waiting result")
    `GSA_ASSERT_IMP(a_found_in_range, r_state == gsa_pkg::S_EXEC && r_found && (r_cmd == gsa_pkg::CMD_ALLOC || r_cmd == gsa_pkg::CMD_NEXT), 16'(r_idx) < 16'(c_lim), "search returned slot beyond limit")
    `GSA_ASSERT_NXT(a_alloc_ok_result, c_commit && r_cmd == gsa_pkg::CMD_ALLOC && r_found, o_out_valid && o_status == gsa_pkg::ST_OK, "allocate result lost")

endmodule

`default_nettype wire
